// ===== sv/dirty_region_bitmap_marker_macros.svh =====
// Assertion macros shared by the dirty-region bitmap marker checkers
`ifndef DIRTY_REGION_BITMAP_MARKER_MACROS_SVH
`define DIRTY_REGION_BITMAP_MARKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DRBM_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DRBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/drbm_pkg.sv =====
// Shared types and constants of the dirty-region bitmap marker
package drbm_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SECTOR_W = 32;
  localparam int unsigned BYTES_W  = 25;
  localparam int unsigned WIDX_IN_W = 10;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BITSEL_W = 5;
  localparam int unsigned RSHIFT_W = 5;

  localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FETCH = 2'd2;

  // Per-word control for the merge unit
  typedef struct packed {
    logic                is_first;
    logic                is_last;
    logic [BITSEL_W-1:0] first_lo;
    logic [BITSEL_W-1:0] last_lo;
  } word_ctl_t;

endpackage

// ===== sv/drbm_if.sv =====
// Valid/ready channel interfaces of the dirty-region bitmap marker

// Request channel
interface drbm_req_if import drbm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [SECTOR_W-1:0]  start_sector;
  logic [BYTES_W-1:0]   byte_count;
  logic [WIDX_IN_W-1:0] word_index;

  modport source (output valid, opcode, start_sector, byte_count, word_index, input ready);
  modport sink   (input valid, opcode, start_sector, byte_count, word_index, output ready);
endinterface

// Result channel
interface drbm_rsp_if import drbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              newly_dirty;
  logic              clamped;
  logic [WORD_W-1:0] map_word;

  modport source (output valid, newly_dirty, clamped, map_word, input ready);
  modport sink   (input valid, newly_dirty, clamped, map_word, output ready);
endinterface

// Configuration write channel
interface drbm_cfg_if import drbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RSHIFT_W-1:0] resolution_shift;

  modport source (output valid, resolution_shift, input ready);
  modport sink   (input valid, resolution_shift, output ready);
endinterface

// ===== sv/drbm_word_unit.sv =====
// Shared mask and merge unit: ORs the range mask into one bitmap word
module drbm_word_unit import drbm_pkg::*; (
  input  word_ctl_t         ctl_i,
  input  logic [WORD_W-1:0] old_word_i,
  output logic [WORD_W-1:0] new_word_o,
  output logic              newly_o
);

  logic [WORD_W-1:0] first_mask;
  logic [WORD_W-1:0] last_mask;
  logic [WORD_W-1:0] mask;

  // Edge masks; 31 - x equals ~x on five bits
  assign first_mask = ctl_i.is_first ? (ALL_ONES << ctl_i.first_lo) : ALL_ONES;
  assign last_mask  = ctl_i.is_last  ? (ALL_ONES >> (~ctl_i.last_lo)) : ALL_ONES;
  assign mask       = first_mask & last_mask;

  assign new_word_o = old_word_i | mask;
  assign newly_o    = ((old_word_i & mask) != mask);

endmodule

// ===== sv/dirty_region_bitmap_marker.sv =====
// Top level of the dirty-region bitmap marker
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   opcode, start_sector, byte_count, word_index
//   rsp_o    out  valid/ready   newly_dirty, clamped, map_word
//   cfg_i    in   valid/ready   resolution_shift (always ready)
//
// After reset the bitmap RAM is cleared one word per cycle, with req_i not
// ready meanwhile. A write passes S_SUM, S_RANGE, then a read and a write of
// each word spanned through the shared merge unit, then S_DONE. A fetch
// passes S_FREAD and S_FDATA (only S_FREAD past the map); read and other
// opcodes go straight to S_DONE. The result register frees the request side:
// the next transaction is taken while the previous result waits.
module dirty_region_bitmap_marker import drbm_pkg::*; #(
  parameter int unsigned MAP_WORDS    = 1024,
  parameter int unsigned SECTOR_SHIFT = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  drbm_req_if.sink    req_i,
  drbm_rsp_if.source  rsp_o,
  drbm_cfg_if.sink    cfg_i
);

  localparam int unsigned WIDX_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W    = WIDX_W + BITSEL_W;
  localparam int unsigned LAST_BIT = MAP_WORDS * WORD_W - 1;

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_RANGE  = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_MERGE  = 4'd5;
  localparam logic [3:0] S_FREAD  = 4'd6;
  localparam logic [3:0] S_FDATA  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [WIDX_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic [RSHIFT_W-1:0]  rshift_q;

  logic [OPCODE_W-1:0]  op_q, op_d;
  logic [SECTOR_W-1:0]  sector_q, sector_d;
  logic [BYTES_W-1:0]   bytes_q, bytes_d;
  logic [WIDX_IN_W-1:0] widx_q, widx_d;
  logic [SECTOR_W:0]    sum_q, sum_d;
  logic [BIT_W-1:0]     first_q, first_d;
  logic [BIT_W-1:0]     last_q, last_d;
  logic [WIDX_W-1:0]    cur_q, cur_d;

  logic                 res_newly_q, res_newly_d;
  logic                 res_clamp_q, res_clamp_d;
  logic [WORD_W-1:0]    res_word_q, res_word_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic                 rsp_newly_q, rsp_newly_d;
  logic                 rsp_clamp_q, rsp_clamp_d;
  logic [WORD_W-1:0]    rsp_word_q, rsp_word_d;

  logic [WORD_W-1:0]    map_mem [MAP_WORDS];
  logic [WORD_W-1:0]    mem_rdata_q;
  logic                 mem_we, mem_re;
  logic [WIDX_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_W-1:0]    mem_wdata;

  logic                 req_acc;
  logic                 rsp_free;
  logic [BYTES_W-1:0]   len_m1;
  logic [SECTOR_W-1:0]  first_full;
  logic [SECTOR_W:0]    last_full;
  logic                 range_clamp;
  word_ctl_t            wctl;
  logic [WORD_W-1:0]    merged_word;
  logic                 merged_newly;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.newly_dirty = rsp_newly_q;
  assign rsp_o.clamped     = rsp_clamp_q;
  assign rsp_o.map_word    = rsp_word_q;

  // Range arithmetic: zero length covers one sector
  assign len_m1      = (bytes_q == '0) ? '0 : (bytes_q - BYTES_W'(1));
  assign first_full  = sector_q >> rshift_q;
  assign last_full   = sum_q >> rshift_q;
  assign range_clamp = (last_full > (SECTOR_W + 1)'(LAST_BIT));

  // Per-word control for the merge unit
  assign wctl.is_first = (cur_q == first_q[BIT_W-1:BITSEL_W]);
  assign wctl.is_last  = (cur_q == last_q[BIT_W-1:BITSEL_W]);
  assign wctl.first_lo = first_q[BITSEL_W-1:0];
  assign wctl.last_lo  = last_q[BITSEL_W-1:0];

  drbm_word_unit u_word_unit (
    .ctl_i      (wctl),
    .old_word_i (mem_rdata_q),
    .new_word_o (merged_word),
    .newly_o    (merged_newly)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    op_d        = op_q;
    sector_d    = sector_q;
    bytes_d     = bytes_q;
    widx_d      = widx_q;
    sum_d       = sum_q;
    first_d     = first_q;
    last_d      = last_q;
    cur_d       = cur_q;
    res_newly_d = res_newly_q;
    res_clamp_d = res_clamp_q;
    res_word_d  = res_word_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_newly_d = rsp_newly_q;
    rsp_clamp_d = rsp_clamp_q;
    rsp_word_d  = rsp_word_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = merged_word;
    mem_re      = 1'b0;
    mem_raddr   = cur_q;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + WIDX_W'(1);
        if (clr_cnt_q == WIDX_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          op_d        = req_i.opcode;
          sector_d    = req_i.start_sector;
          bytes_d     = req_i.byte_count;
          widx_d      = req_i.word_index;
          res_newly_d = 1'b0;
          res_clamp_d = 1'b0;
          res_word_d  = '0;
          case (req_i.opcode)
            OP_WRITE: state_d = S_SUM;
            OP_FETCH: state_d = S_FREAD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_SUM: begin
        sum_d   = (SECTOR_W + 1)'(sector_q) + (SECTOR_W + 1)'(len_m1 >> SECTOR_SHIFT);
        state_d = S_RANGE;
      end
      S_RANGE: begin
        // Clamp the last end, and the first if it too lies past, to the last map bit when the range runs past it
        res_clamp_d = range_clamp;
        if (range_clamp) begin
          last_d  = BIT_W'(LAST_BIT);
          first_d = (first_full > SECTOR_W'(LAST_BIT)) ? BIT_W'(LAST_BIT)
                                                       : first_full[BIT_W-1:0];
        end else begin
          last_d  = last_full[BIT_W-1:0];
          first_d = first_full[BIT_W-1:0];
        end
        cur_d   = first_d[BIT_W-1:BITSEL_W];
        state_d = S_READ;
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        mem_we      = 1'b1;
        res_newly_d = res_newly_q | merged_newly;
        if (wctl.is_last) begin
          state_d = S_DONE;
        end else begin
          cur_d   = cur_q + WIDX_W'(1);
          state_d = S_READ;
        end
      end
      S_FREAD: begin
        if ((WIDX_IN_W + 17)'(widx_q) < (WIDX_IN_W + 17)'(MAP_WORDS)) begin
          mem_re    = 1'b1;
          mem_raddr = WIDX_W'(widx_q);
          state_d   = S_FDATA;
        end else begin
          res_clamp_d = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_FDATA: begin
        res_word_d = mem_rdata_q;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_newly_d = res_newly_q;
          rsp_clamp_d = res_clamp_q;
          rsp_word_d  = res_word_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      rshift_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        rshift_q <= cfg_i.resolution_shift;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    sector_q    <= sector_d;
    bytes_q     <= bytes_d;
    widx_q      <= widx_d;
    sum_q       <= sum_d;
    first_q     <= first_d;
    last_q      <= last_d;
    cur_q       <= cur_d;
    res_newly_q <= res_newly_d;
    res_clamp_q <= res_clamp_d;
    res_word_q  <= res_word_d;
    rsp_newly_q <= rsp_newly_d;
    rsp_clamp_q <= rsp_clamp_d;
    rsp_word_q  <= rsp_word_d;
  end

  // Bitmap RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= map_mem[mem_raddr];
    end
  end

endmodule

// ===== sv/drbm_checker.sv =====
// Port-level checker of the dirty-region bitmap marker, with its bind
`include "dirty_region_bitmap_marker_macros.svh"

module drbm_checker import drbm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_newly_dirty,
  input logic              rsp_clamped,
  input logic [WORD_W-1:0] rsp_map_word
);

  // One transaction at a time: ready drops right after an accept
  `DRBM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid && req_ready, !req_ready, "request accepted while busy")

  // A stalled result stays put
  `DRBM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_map_word) && $stable(rsp_newly_dirty) && $stable(rsp_clamped), "stalled result changed")

  // Only a fetch carries a word, and a fetch never reports newly dirty bits
  `DRBM_ASSERT_IMPLIES(a_newly_no_word, clk_i, rst_ni, rsp_valid && rsp_newly_dirty, rsp_map_word == '0, "newly_dirty with a map word")

  // A clamped fetch returns zero, a write returns no word
  `DRBM_ASSERT_IMPLIES(a_word_not_clamped, clk_i, rst_ni, rsp_valid && (rsp_map_word != '0), !rsp_clamped, "map word on a clamped result")

endmodule

bind dirty_region_bitmap_marker drbm_checker u_drbm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .rsp_newly_dirty (rsp_o.newly_dirty),
  .rsp_clamped     (rsp_o.clamped),
  .rsp_map_word    (rsp_o.map_word)
);

// ===== dv/dirty_region_bitmap_marker_tb.sv =====
// Self-checking testbench for the dirty-region bitmap marker: directed table, then random phases
module dirty_region_bitmap_marker_tb;
  import drbm_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned MAP_WORDS    = 1024;
  localparam int unsigned SECTOR_SHIFT = 9;
  localparam longint unsigned LAST_MAP_BIT = longint'(MAP_WORDS) * 32 - 1;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 85;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned DIR_ROWS     = 21;

  // Opcode 3 is undefined and behaves like a read
  localparam logic [OPCODE_W-1:0] OP_RSVD = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [SECTOR_W-1:0]  start_sector;
    logic [BYTES_W-1:0]   byte_count;
    logic [WIDX_IN_W-1:0] word_index;
  } request_t;

  typedef struct packed {
    logic              newly_dirty;
    logic              clamped;
    logic [WORD_W-1:0] map_word;
  } status_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    status_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  drbm_req_if req_ch ();
  drbm_rsp_if rsp_ch ();
  drbm_cfg_if cfg_ch ();

  dirty_region_bitmap_marker #(
    .MAP_WORDS    (MAP_WORDS),
    .SECTOR_SHIFT (SECTOR_SHIFT)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the bitmap and the shift register
  logic [WORD_W-1:0]   shadow_map [MAP_WORDS];
  logic [RSHIFT_W-1:0] shadow_shift;

  status_t     awaited_results [$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned req_gap_pct;
  int unsigned rsp_gap_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned recent_word;

  // Directed rows, all at shift 0 on a freshly cleared map
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd0},    1'b1, '{1'b0, 1'b0, 32'h0}},
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd1023}, 1'b1, '{1'b0, 1'b0, 32'h0}},
    '{'{OP_WRITE, 32'd0,          25'd1,        10'd0},    1'b1, '{1'b1, 1'b0, 32'h0}},
    '{'{OP_WRITE, 32'd0,          25'd1,        10'd0},    1'b1, '{1'b0, 1'b0, 32'h0}},
    // zero byte count covers the start sector alone
    '{'{OP_WRITE, 32'd1,          25'd0,        10'd0},    1'b1, '{1'b1, 1'b0, 32'h0}},
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd0},    1'b1, '{1'b0, 1'b0, 32'h3}},
    '{'{OP_READ,  32'd1,          25'd1,        10'd0},    1'b1, '{1'b0, 1'b0, 32'h0}},
    '{'{OP_RSVD,  32'hffff_ffff,  25'd16777216, 10'd1023}, 1'b1, '{1'b0, 1'b0, 32'h0}},
    // range wholly past the map marks only the last bit
    '{'{OP_WRITE, 32'hffff_ffff,  25'd16777216, 10'd0},    1'b1, '{1'b1, 1'b1, 32'h0}},
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd1023}, 1'b1, '{1'b0, 1'b0, 32'h8000_0000}},
    '{'{OP_WRITE, 32'd32766,      25'd1024,     10'd0},    1'b0, '0},
    // range running off the end of the map
    '{'{OP_WRITE, 32'd32760,      25'd8193,     10'd0},    1'b0, '0},
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd1023}, 1'b0, '0},
    '{'{OP_WRITE, 32'd32,         25'd16384,    10'd0},    1'b0, '0},
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd1},    1'b0, '0},
    '{'{OP_WRITE, 32'd31,         25'd1024,     10'd0},    1'b0, '0},
    // three words, each marked in full
    '{'{OP_WRITE, 32'd64,         25'd49152,    10'd0},    1'b0, '0},
    '{'{OP_WRITE, 32'd64,         25'd49152,    10'd0},    1'b0, '0},
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd0},    1'b0, '0},
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd3},    1'b0, '0},
    '{'{OP_FETCH, 32'd0,          25'd1,        10'd4},    1'b0, '0}
  };

  logic [RSHIFT_W-1:0] phase_shift [PHASES] = '{
    5'd0, 5'd31, 5'd7, 5'd1, 5'd20, 5'd0, 5'd15, 5'd3, 5'd31, 5'd12
  };

  // Apply one request to the shadow map and return the status it yields
  function automatic status_t apply_to_shadow_map(request_t item);
    status_t         res;
    longint unsigned first_bit;
    longint unsigned last_bit;
    longint unsigned span;
    int unsigned     w_lo;
    int unsigned     w_hi;
    int unsigned     w;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    res = '0;
    case (item.opcode)
      OP_WRITE: begin
        span = (item.byte_count == '0) ? 64'd0 :
               (64'(item.byte_count) - 64'd1) >> SECTOR_SHIFT;
        first_bit = 64'(item.start_sector) >> shadow_shift;
        last_bit  = (64'(item.start_sector) + span) >> shadow_shift;
        if (last_bit > LAST_MAP_BIT) begin
          res.clamped = 1'b1;
          last_bit = LAST_MAP_BIT;
          if (first_bit > LAST_MAP_BIT) first_bit = LAST_MAP_BIT;
        end
        w_lo = int'(first_bit >> 5);
        w_hi = int'(last_bit >> 5);
        lo_mask = ALL_ONES << first_bit[4:0];
        hi_mask = ALL_ONES >> (5'd31 - last_bit[4:0]);
        for (w = w_lo; w <= w_hi; w++) begin
          mask = ALL_ONES;
          if (w == w_lo) mask &= lo_mask;
          if (w == w_hi) mask &= hi_mask;
          if ((shadow_map[w] & mask) != mask) res.newly_dirty = 1'b1;
          shadow_map[w] |= mask;
        end
      end
      OP_FETCH: begin
        if (item.word_index < MAP_WORDS) res.map_word = shadow_map[item.word_index];
        else res.clamped = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random request: mostly in-map writes and fetches near recent writes
  function automatic request_t random_request(logic [RSHIFT_W-1:0] shift);
    request_t    item;
    int unsigned pick;
    int unsigned target_bit;
    item.start_sector = $urandom;
    item.byte_count   = BYTES_W'($urandom_range(1, 16777216));
    item.word_index   = WIDX_IN_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 55) item.opcode = OP_WRITE;
    else if (pick < 65) item.opcode = OP_READ;
    else if (pick < 95) item.opcode = OP_FETCH;
    else item.opcode = OP_RSVD;

    if (item.opcode == OP_WRITE) begin
      target_bit = ($urandom_range(0, 9) == 0) ? $urandom_range(32700, 32767) :
                                                 $urandom_range(0, 32767);
      // wide shifts keep any sector inside the map
      if ($urandom_range(0, 19) != 0 && shift < 17)
        item.start_sector = (32'(target_bit) << shift) | ($urandom & ((32'd1 << shift) - 32'd1));
      recent_word = target_bit >> 5;
      pick = $urandom_range(0, 99);
      if (shift >= 15) begin
        if (pick < 10) item.byte_count = BYTES_W'(16777216);
        else if (pick < 15) item.byte_count = '0;
      end else begin
        if (pick < 5) item.byte_count = '0;
        else if (pick < 75) item.byte_count = BYTES_W'($urandom_range(1, 16384));
        else item.byte_count = BYTES_W'($urandom_range(1, 131072));
      end
    end else if (item.opcode == OP_FETCH && $urandom_range(0, 1) == 0) begin
      item.word_index = WIDX_IN_W'(recent_word);
    end
    return item;
  endfunction

  function automatic void flag_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", what);
  endfunction

  // Offer one request with random idle cycles in front, record its expected status
  task automatic offer_request(input request_t item, input logic typed, input status_t want);
    status_t predicted;
    while ($urandom_range(0, 99) < req_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= item.opcode;
    req_ch.start_sector <= item.start_sector;
    req_ch.byte_count   <= item.byte_count;
    req_ch.word_index   <= item.word_index;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_to_shadow_map(item);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Drain all outstanding results, then write the shift register
  task automatic write_shift_when_idle(input logic [RSHIFT_W-1:0] value);
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.resolution_shift <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_shift = value;
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    status_t want;
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_results.size() == 0) begin
          flag_failure($sformatf("unexpected result: newly_dirty %0b clamped %0b map_word %h",
                                 rsp_ch.newly_dirty, rsp_ch.clamped, rsp_ch.map_word));
        end else begin
          want = awaited_results.pop_front();
          if (rsp_ch.newly_dirty !== want.newly_dirty)
            flag_failure($sformatf("newly_dirty: expected %0b, got %0b",
                                   want.newly_dirty, rsp_ch.newly_dirty));
          if (rsp_ch.clamped !== want.clamped)
            flag_failure($sformatf("clamped: expected %0b, got %0b",
                                   want.clamped, rsp_ch.clamped));
          if (rsp_ch.map_word !== want.map_word)
            flag_failure($sformatf("map_word: expected %h, got %h",
                                   want.map_word, rsp_ch.map_word));
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Result receiver: random back-pressure plus requested long holds
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_gap_pct);
    end
  end

  // Stimulus
  initial begin
    int unsigned row;
    int unsigned phase;
    int unsigned n;
    fail_count    = 0;
    idle_cycles   = 0;
    hold_requests = 0;
    hold_served   = 0;
    recent_word   = 0;
    shadow_shift  = '0;
    foreach (shadow_map[i]) shadow_map[i] = '0;
    req_gap_pct = 25;
    rsp_gap_pct = 77;

    rst_n                   <= 1'b0;
    req_ch.valid            <= 1'b0;
    req_ch.opcode           <= OP_READ;
    req_ch.start_sector     <= '0;
    req_ch.byte_count       <= '0;
    req_ch.word_index       <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.resolution_shift <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_shift_when_idle(5'd0);
    for (row = 0; row < DIR_ROWS; row++)
      offer_request(directed_rows[row].req, directed_rows[row].typed, directed_rows[row].want);

    // Random phases: receiver-side stalls, then sender-side idling, then none
    for (phase = 0; phase < PHASES; phase++) begin
      write_shift_when_idle(phase_shift[phase]);
      if (phase < 4) begin
        req_gap_pct = 25;
        rsp_gap_pct = 77;
      end else if (phase < 7) begin
        req_gap_pct = 77;
        rsp_gap_pct = 25;
      end else begin
        req_gap_pct = 0;
        rsp_gap_pct = 0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 7 && n == 5) hold_requests++;
        offer_request(random_request(phase_shift[phase]), 1'b0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
